/* sv/light_radius_animator_macros.svh */
// ----------------------------------------------------------------------------
// light_radius_animator_macros
// Assertion macros shared by the light radius animator RTL. In synthesis
// builds they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef LIGHT_RADIUS_ANIMATOR_MACROS_SVH
`define LIGHT_RADIUS_ANIMATOR_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define LRA_ASSERT_IMPL(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("light_radius_animator: assertion failed");
// next-cycle implication, disabled while reset is asserted
`define LRA_ASSERT_NEXT(name, clock, rstn, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("light_radius_animator: assertion failed");
`else
`define LRA_ASSERT_IMPL(name, clock, rstn, ante, cons)
`define LRA_ASSERT_NEXT(name, clock, rstn, ante, cons)
`endif

`endif

/* sv/lra_pkg.sv */
// ----------------------------------------------------------------------------
// lra_pkg
// Kind codes, hash constants, divider geometry and the side-band record that
// travels down the light radius pipeline.
// ----------------------------------------------------------------------------
package lra_pkg;

	localparam logic [1:0] KIND_POINT   = 2'd0;
	localparam logic [1:0] KIND_PULSE   = 2'd1;
	localparam logic [1:0] KIND_FLICKER = 2'd2;

	localparam logic [31:0] HASH_TICK_MUL = 32'd1664525;
	localparam logic [31:0] HASH_SEED_MUL = 32'd1013904223;
	localparam logic [31:0] HASH_MIX_MUL  = 32'd2246822519;
	localparam int          HASH_SHIFT_A  = 15;
	localparam int          HASH_SHIFT_B  = 13;

	// floor(2^40 / 360): quotient estimate is exact or one low for 32-bit values
	localparam logic [31:0] RECIP_360     = 32'd3054198966;
	localparam int          RECIP_SHIFT   = 40;
	localparam logic [9:0]  FLICK_MOD     = 10'd360;

	localparam int DVD_W      = 32;
	localparam int DVS_W      = 16;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = DVD_W / DIV_STEP;

	typedef struct packed {
		logic [15:0] base;
		logic [15:0] alt;
		logic [8:0]  odds;
		logic        pulse;
		logic        flick;
		logic        pick;
	} carry_t;

endpackage

/* sv/lra_div.sv */
// ----------------------------------------------------------------------------
// lra_div
// Pipelined restoring divider, 32-bit dividend by 16-bit divisor, four
// quotient bits per stage. Each stage loads when its enable is high.
// ----------------------------------------------------------------------------
module lra_div (
	input  logic                                clk,
	input  logic [lra_pkg::DIV_STAGES-1:0]      stage_en,
	input  logic [lra_pkg::DVD_W-1:0]           dividend,
	input  logic [lra_pkg::DVS_W-1:0]           divisor,
	output logic [lra_pkg::DVD_W-1:0]           quotient
);

	localparam int NST = lra_pkg::DIV_STAGES;
	localparam int DW  = lra_pkg::DVD_W;
	localparam int SW  = lra_pkg::DVS_W;

	// remainder, shifting dividend/quotient word and divisor for each stage
	logic [SW-1:0] rem_s [NST];
	logic [DW-1:0] word_s [NST];
	logic [SW-1:0] dvs_s [NST];

	logic [SW-1:0] rem_in [NST];
	logic [DW-1:0] word_in [NST];
	logic [SW-1:0] dvs_in [NST];

	function automatic logic [SW+DW-1:0] div_steps(input logic [SW-1:0] rem_i,
		input logic [DW-1:0] word_i, input logic [SW-1:0] dvs);
		logic [SW:0]   t;
		logic [SW-1:0] r;
		logic [DW-1:0] w;
		r = rem_i;
		w = word_i;
		for (int i = 0; i < lra_pkg::DIV_STEP; i++) begin
			t = {r, w[DW-1]};
			w = {w[DW-2:0], 1'b0};
			if (t >= {1'b0, dvs}) begin
				t    = t - {1'b0, dvs};
				w[0] = 1'b1;
			end
			r = t[SW-1:0];
		end
		return {r, w};
	endfunction

	always_comb begin
		rem_in[0]  = '0;
		word_in[0] = dividend;
		dvs_in[0]  = divisor;
		for (int k = 1; k < NST; k++) begin
			rem_in[k]  = rem_s[k-1];
			word_in[k] = word_s[k-1];
			dvs_in[k]  = dvs_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NST; k++) begin
			if (stage_en[k]) begin
				{rem_s[k], word_s[k]} <= div_steps(rem_in[k], word_in[k], dvs_in[k]);
				dvs_s[k]              <= dvs_in[k];
			end
		end
	end

	assign quotient = word_s[NST-1];

endmodule

/* sv/lra_sine_rom.sv */
// ----------------------------------------------------------------------------
// lra_sine_rom
// Quarter-wave sine table with registered read. Entry a holds the magnitude
// of sin((a + 1/2) * 2*pi / SINE_STEPS) in FRAC_WIDTH fraction bits,
// truncated; contents are fixed at elaboration.
// ----------------------------------------------------------------------------
module lra_sine_rom #(
	parameter int SINE_STEPS = 8192,
	parameter int FRAC_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [$clog2(SINE_STEPS)-3:0] addr,
	output logic [FRAC_WIDTH-1:0]         mag
);

	localparam int  QUARTER = SINE_STEPS / 4;
	localparam real PI      = 3.14159265358979323846;

	logic [FRAC_WIDTH-1:0] table_c [QUARTER];
	logic [FRAC_WIDTH-1:0] mag_q;

	for (genvar g = 0; g < QUARTER; g++) begin : g_entry
		assign table_c[g] = FRAC_WIDTH'($rtoi($sin((2.0 * g + 1.0) * PI / SINE_STEPS)
			* (2.0 ** FRAC_WIDTH)));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= table_c[addr];
		end
	end

	assign mag = mag_q;

endmodule

/* sv/light_radius_animator.sv */
// ----------------------------------------------------------------------------
// light_radius_animator
// Current radius of one light at one tick: point, sine pulse or hashed
// flicker.
// ----------------------------------------------------------------------------
// Usage:
//   Present a light on the item channel (item_valid/item_ready, one port per
//   field); the radius comes back on the result channel
//   (result_valid/result_ready), one result per item, in order.
//   The pipeline has DIV_STAGES + 5 = 13 register stages: an accepted item
//   passes through them in order, and result_valid rises when it reaches
//   the output register.
//   Throughput is one item per cycle unless stalled; the depth is set by an
//   input register, the pulse divider, which resolves four quotient bits in
//   each of its eight stages, then the sine table read, the scale factor, the
//   multiply and the output register; the flicker hash shares these stages.
//   Reset clears every stage valid bit; the block then accepts at once.
//   When the receiver holds result_ready low, the output stage keeps its
//   transaction and a stage holds while it and all stages after it are full;
//   empty stages still fill, so item_ready drops only when all are full.
// ----------------------------------------------------------------------------
`include "light_radius_animator_macros.svh"

module light_radius_animator #(
	parameter int SINE_STEPS = 8192,
	parameter int FRAC_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  light_kind,
	input  logic [15:0] base_size,
	input  logic [15:0] alt_size,
	input  logic [15:0] pulse_period,
	input  logic [8:0]  flicker_odds,
	input  logic [31:0] tick_count,
	input  logic [31:0] light_seed,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] radius
);

	localparam int PHASE_W = $clog2(SINE_STEPS);
	localparam int ADDR_W  = PHASE_W - 2;
	localparam int S_QUO   = lra_pkg::DIV_STAGES + 1;
	localparam int S_ROM   = S_QUO + 1;
	localparam int S_FRAC  = S_ROM + 1;
	localparam int S_PROD  = S_FRAC + 1;
	localparam int NS      = S_PROD + 1;
	localparam int S_PICK  = 6;

	logic [NS:1] valid_q;
	logic [NS:1] en;
	logic [NS:1] valid_nxt;

	// side-band record per stage, stage index in the array
	lra_pkg::carry_t carry_s [1:NS-1];
	lra_pkg::carry_t carry_in_c;
	lra_pkg::carry_t carry_pick_c;

	logic [31:0] scaled_s1;
	logic [15:0] period_s1;
	logic [31:0] hash_a_s1;
	logic [31:0] hash_b_s1;
	logic [31:0] hash1_s2;
	logic [31:0] hash2_s3;
	logic [23:0] qest_s4;
	logic [9:0]  hlow_s4;
	logic [9:0]  rem_s5;

	logic [31:0] quo;
	logic [PHASE_W-1:0] phase;
	logic [ADDR_W-1:0]  rom_addr;
	logic [FRAC_WIDTH-1:0] mag;
	logic        neg_s10;
	logic [FRAC_WIDTH-1:0] frac_s11;
	logic signed [16:0]    diff_s11;
	logic signed [FRAC_WIDTH+17:0] prod_s12;
	logic [15:0] radius_s13;

	logic [31:0] hash_sum;
	logic [31:0] hash3_c;
	logic [63:0] qprod_c;
	logic [9:0]  rem_fix_c;
	logic        pick_c;
	logic [FRAC_WIDTH:0] frac_sum_c;
	logic [15:0] delta_c;

	// ---------------------------------------------------------------- control
	always_comb begin
		logic [NS:1] mask;
		for (int k = 1; k <= NS; k++) begin
			mask  = {NS{1'b1}} << (k - 1);
			en[k] = result_ready | ((valid_q & mask) != mask);
		end
	end

	assign valid_nxt    = {valid_q[NS-1:1], item_valid};
	assign item_ready   = en[1];
	assign result_valid = valid_q[NS];
	assign radius       = radius_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_nxt[k];
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_comb begin
		carry_in_c.base  = base_size;
		carry_in_c.alt   = alt_size;
		carry_in_c.odds  = flicker_odds;
		carry_in_c.pulse = (light_kind == lra_pkg::KIND_PULSE) && (pulse_period != 16'd0);
		carry_in_c.flick = (light_kind == lra_pkg::KIND_FLICKER);
		carry_in_c.pick  = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			scaled_s1 <= {tick_count[31-PHASE_W:0], {PHASE_W{1'b0}}};
			period_s1 <= pulse_period;
			hash_a_s1 <= 32'(tick_count * lra_pkg::HASH_TICK_MUL);
			hash_b_s1 <= 32'(light_seed * lra_pkg::HASH_SEED_MUL);
		end
	end

	// drop the flicker decision in once it is known
	always_comb begin
		carry_pick_c      = carry_s[S_PICK-1];
		carry_pick_c.pick = pick_c;
	end

	// side-band shift
	always_ff @(posedge clk) begin
		if (en[1]) begin
			carry_s[1] <= carry_in_c;
		end
		for (int k = 2; k < NS; k++) begin
			if (en[k]) begin
				carry_s[k] <= (k == S_PICK) ? carry_pick_c : carry_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------- flicker hash
	assign hash_sum  = hash_a_s1 + hash_b_s1;
	assign hash3_c   = hash2_s3 ^ (hash2_s3 >> lra_pkg::HASH_SHIFT_B);
	assign qprod_c   = 64'(hash3_c) * 64'(lra_pkg::RECIP_360);
	// estimate may be one low: remainder lies below twice the modulus
	assign rem_fix_c = (rem_s5 >= lra_pkg::FLICK_MOD) ? rem_s5 - lra_pkg::FLICK_MOD : rem_s5;
	assign pick_c    = rem_fix_c < {1'b0, carry_s[S_PICK-1].odds};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			hash1_s2 <= hash_sum ^ (hash_sum >> lra_pkg::HASH_SHIFT_A);
		end
		if (en[3]) begin
			hash2_s3 <= 32'(hash1_s2 * lra_pkg::HASH_MIX_MUL);
		end
		if (en[4]) begin
			qest_s4 <= qprod_c[lra_pkg::RECIP_SHIFT+23:lra_pkg::RECIP_SHIFT];
			hlow_s4 <= hash3_c[9:0];
		end
		if (en[5]) begin
			rem_s5 <= hlow_s4 - 10'(qest_s4 * lra_pkg::FLICK_MOD);
		end
	end

	// ------------------------------------------------------------ pulse path
	lra_div u_div (
		.clk      (clk),
		.stage_en (en[S_QUO:2]),
		.dividend (scaled_s1),
		.divisor  (period_s1),
		.quotient (quo)
	);

	// fold the phase onto the first quarter wave
	assign phase    = quo[PHASE_W-1:0];
	assign rom_addr = phase[PHASE_W-2] ? ~phase[ADDR_W-1:0] : phase[ADDR_W-1:0];

	lra_sine_rom #(
		.SINE_STEPS (SINE_STEPS),
		.FRAC_WIDTH (FRAC_WIDTH)
	) u_rom (
		.clk  (clk),
		.en   (en[S_ROM]),
		.addr (rom_addr),
		.mag  (mag)
	);

	assign frac_sum_c = neg_s10 ? ((FRAC_WIDTH+1)'(1) << FRAC_WIDTH) - {1'b0, mag}
		: ((FRAC_WIDTH+1)'(1) << FRAC_WIDTH) + {1'b0, mag};
	assign delta_c    = prod_s12[FRAC_WIDTH+15:FRAC_WIDTH];

	always_ff @(posedge clk) begin
		if (en[S_ROM]) begin
			neg_s10 <= phase[PHASE_W-1];
		end
		if (en[S_FRAC]) begin
			frac_s11 <= frac_sum_c[FRAC_WIDTH:1];
			diff_s11 <= $signed({1'b0, carry_s[S_FRAC-1].alt})
				- $signed({1'b0, carry_s[S_FRAC-1].base});
		end
		if (en[S_PROD]) begin
			prod_s12 <= diff_s11 * $signed({1'b0, frac_s11});
		end
		if (en[NS]) begin
			if (carry_s[S_PROD].pulse) begin
				radius_s13 <= carry_s[S_PROD].base + delta_c;
			end else if (carry_s[S_PROD].flick) begin
				radius_s13 <= carry_s[S_PROD].pick ? carry_s[S_PROD].base
					: carry_s[S_PROD].alt;
			end else begin
				radius_s13 <= carry_s[S_PROD].base;
			end
		end
	end

	// ------------------------------------------------------------ assertions
	`LRA_ASSERT_IMPL(a_full_stall_blocks, clk, arst_n, (&valid_q) && !result_ready, !item_ready)
	`LRA_ASSERT_IMPL(a_bubble_accepts, clk, arst_n, !(&valid_q), item_ready)
	`LRA_ASSERT_NEXT(a_stage1_holds, clk, arst_n, valid_q[1] && !en[1], valid_q[1])
	`LRA_ASSERT_IMPL(a_kind_exclusive, clk, arst_n, valid_q[S_PROD], ($onehot0({carry_s[S_PROD].pulse, carry_s[S_PROD].flick})))

endmodule
